// File: design/rleq_pkg.sv
package rleq_pkg;

   // Stream payload widths, fields packed from bit 0 upwards
   localparam int REQ_TDATA_W = 120;
   localparam int RSP_TDATA_W = 88;
   localparam int POS_W       = 32;
   localparam int KIND_W      = 8;
   localparam int TIME_W      = 32;
   localparam int DT_W        = 16;
   localparam int CNT_OUT_W   = 6;
   localparam int CSR_DATA_W  = 32;

   // Reset values of the configuration registers
   localparam logic [TIME_W-1:0] LIFETIME_RESET = 32'd5000;
   localparam logic [TIME_W-1:0] FLOOR_RESET    = 32'd2000;

   // Configuration register indexes
   localparam logic CSR_LIFETIME = 1'b0;
   localparam logic CSR_FLOOR    = 1'b1;

   // Request kinds carried in req_tuser
   localparam logic REQ_RAISE = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef enum logic [1:0] {
      ST_RAISED   = 2'd0,
      ST_RATE     = 2'd1,
      ST_BAD_KIND = 2'd2,
      ST_TICK     = 2'd3
   } rsp_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RCHK,
      S_TADV,
      S_TREAD,
      S_TCHK,
      S_LREAD,
      S_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic           capture;
      logic           set_status;
      rsp_status_type status_code;
      logic           commit_raise;
      logic           advance_clock;
      logic           read_head;
      logic           pop_head;
      logic           read_latest;
      logic           load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic bad_kind;
      logic rate_hit;
      logic dt_zero;
      logic queue_empty;
      logic last_entry;
      logic head_expired;
      logic rsp_stall;
   } dp_status_type;

endpackage

// File: design/rate_limited_expiring_event_queue_top.sv
// Channel  | Direction | Handshake             | Payload
// request  | in        | req_tvalid/req_tready | req_tdata 120b, req_tuser 1b (raise/tick)
// response | out       | rsp_tvalid/rsp_tready | rsp_tdata 88b, rsp_tuser 2b (status)
// config   | in        | csr_wr_en             | csr_index 1b, csr_wdata 32b
//
// A raise passes from acceptance to a loaded response through accept, rate check
// against the last-raise memory, newest-entry read and response load.
// A tick advances the aging clock and pops expired head entries, both skipped when
// dt is zero; the birth memory gives one head entry per cycle.
// Reset is synchronous and clears pointers, aging clock and kind history; the
// entry memories need no clearing pass.
// A stalled response holds in the output register; the next request is accepted
// meanwhile and waits only at its own response load.
module rate_limited_expiring_event_queue_top
   import rleq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32,
   parameter int KIND_COUNT  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // pos_x[31:0], pos_y[63:32], kind[71:64], now_ms[103:72], dt_ms[119:104]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                   req_tuser,
   // response
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // evicted[0], expired_count[6:1], entry_count[12:7], latest_valid[13],
   // latest_x[45:14], latest_y[77:46], latest_kind[85:78], zero fill [87:86]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]             rsp_tuser,
   // configuration writes
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequence each request: rate check, expiry scan, response load
   rleq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   // Hold the queue memories, pointers, aging clock and the response register
   rleq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .KIND_COUNT  (KIND_COUNT)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

endmodule

// File: design/rleq_ram.sv
module rleq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/rleq_ctrl.sv
module rleq_ctrl
   import rleq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tuser,
   output logic          req_tready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      dp_cmd     = '0;
      dp_cmd.status_code = ST_TICK;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd.capture = 1'b1;
               state_in = (req_tuser == REQ_TICK) ? S_TADV : S_RCHK;
            end
         end
         S_RCHK: begin
            dp_cmd.set_status = 1'b1;
            if (dp_status.bad_kind) begin
               dp_cmd.status_code = ST_BAD_KIND;
            end else if (dp_status.rate_hit) begin
               dp_cmd.status_code = ST_RATE;
            end else begin
               dp_cmd.status_code  = ST_RAISED;
               dp_cmd.commit_raise = 1'b1;
            end
            state_in = S_LREAD;
         end
         S_TADV: begin
            dp_cmd.set_status  = 1'b1;
            dp_cmd.status_code = ST_TICK;
            if (dp_status.dt_zero) begin
               state_in = S_LREAD;
            end else begin
               dp_cmd.advance_clock = 1'b1;
               state_in = S_TREAD;
            end
         end
         S_TREAD: begin
            if (dp_status.queue_empty) begin
               state_in = S_LREAD;
            end else begin
               dp_cmd.read_head = 1'b1;
               state_in = S_TCHK;
            end
         end
         S_TCHK: begin
            // pop also fetches the birth of the following entry
            if (dp_status.head_expired) begin
               dp_cmd.pop_head = 1'b1;
               if (dp_status.last_entry) begin
                  state_in = S_LREAD;
               end
            end else begin
               state_in = S_LREAD;
            end
         end
         S_LREAD: begin
            dp_cmd.read_latest = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!dp_status.rsp_stall) begin
               dp_cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: design/rleq_dpath.sv
module rleq_dpath
   import rleq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32,
   parameter int KIND_COUNT  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]             rsp_tuser,
   input  dp_cmd_type             dp_cmd,
   output dp_status_type          dp_status
);

   localparam int PW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW     = $clog2(QUEUE_DEPTH + 1);
   localparam int KW     = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;
   localparam int KSLOTS = 1 << KW;
   localparam int ENT_W  = 2 * POS_W + KIND_W;
   localparam logic [CW:0]   DEPTH_W = (CW + 1)'(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

   // Request fields
   logic [POS_W-1:0]  px_ff, py_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [TIME_W-1:0] now_ff;
   logic [DT_W-1:0]   dt_ff;

   // Queue and timing state
   logic [PW-1:0]     head_ff, head_in;
   logic [CW-1:0]     occ_ff, occ_in;
   logic [TIME_W-1:0] aging_ff, aging_in;
   logic [KSLOTS-1:0] seen_ff, seen_in;
   logic [TIME_W-1:0] lifetime_ff, floor_ff;

   // Result bookkeeping
   rsp_status_type    status_ff;
   logic              evicted_ff;
   logic [CW-1:0]     expired_ff;
   logic              rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   rsp_status_type    rsp_status_ff;

   // Pointer arithmetic
   logic [CW:0]   tail_sum, tail_wrap, newest_sum, newest_wrap;
   logic [PW-1:0] tail_slot, newest_slot, head_next, wr_slot;
   logic          queue_full;
   logic [KW-1:0] kind_idx;

   // Memory ports
   logic [TIME_W-1:0] last_time_rd, birth_rd;
   logic [ENT_W-1:0]  entry_rd;
   logic [PW-1:0]     birth_rd_addr;
   logic [TIME_W-1:0] since_last, head_age;
   logic              latest_valid;
   logic [POS_W-1:0]  latest_x, latest_y;
   logic [KIND_W-1:0] latest_kind;

   assign kind_idx   = kind_ff[KW-1:0];
   assign queue_full = ({1'b0, occ_ff} == DEPTH_W);

   always_comb begin
      tail_sum    = (CW + 1)'(head_ff) + (CW + 1)'(occ_ff);
      tail_wrap   = (tail_sum >= DEPTH_W) ? tail_sum - DEPTH_W : tail_sum;
      newest_sum  = tail_sum - (CW + 1)'(1);
      newest_wrap = (newest_sum >= DEPTH_W) ? newest_sum - DEPTH_W : newest_sum;
      tail_slot   = tail_wrap[PW-1:0];
      newest_slot = newest_wrap[PW-1:0];
      head_next   = (head_ff == LAST_SLOT) ? '0 : head_ff + PW'(1);
      // a full queue reuses the head slot once the head is evicted
      wr_slot     = queue_full ? head_ff : tail_slot;
   end

   assign birth_rd_addr = dp_cmd.pop_head ? head_next : head_ff;
   assign since_last    = now_ff - last_time_rd;
   assign head_age      = aging_ff - birth_rd;

   rleq_ram #(.WIDTH(TIME_W), .DEPTH(KIND_COUNT)) u_last_raise (
      .clock   (clock),
      .wr_en   (dp_cmd.commit_raise),
      .wr_addr (kind_idx),
      .wr_data (now_ff),
      .rd_en   (dp_cmd.capture),
      .rd_addr (req_tdata[64 +: KW]),
      .rd_data (last_time_rd)
   );

   rleq_ram #(.WIDTH(TIME_W), .DEPTH(QUEUE_DEPTH)) u_birth (
      .clock   (clock),
      .wr_en   (dp_cmd.commit_raise),
      .wr_addr (wr_slot),
      .wr_data (aging_ff),
      .rd_en   (dp_cmd.read_head | dp_cmd.pop_head),
      .rd_addr (birth_rd_addr),
      .rd_data (birth_rd)
   );

   rleq_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_entry (
      .clock   (clock),
      .wr_en   (dp_cmd.commit_raise),
      .wr_addr (wr_slot),
      .wr_data ({kind_ff, py_ff, px_ff}),
      .rd_en   (dp_cmd.read_latest),
      .rd_addr (newest_slot),
      .rd_data (entry_rd)
   );

   always_comb begin
      dp_status.bad_kind     = ({1'b0, kind_ff} >= 9'(KIND_COUNT));
      dp_status.rate_hit     = seen_ff[kind_idx] && (since_last < floor_ff);
      dp_status.dt_zero      = (dt_ff == '0);
      dp_status.queue_empty  = (occ_ff == '0);
      dp_status.last_entry   = (occ_ff == CW'(1));
      dp_status.head_expired = (head_age > lifetime_ff);
      dp_status.rsp_stall    = rsp_valid_ff && !rsp_tready;
   end

   always_comb begin
      head_in  = head_ff;
      occ_in   = occ_ff;
      aging_in = aging_ff;
      seen_in  = seen_ff;
      if (dp_cmd.commit_raise) begin
         seen_in[kind_idx] = 1'b1;
         if (queue_full) begin
            head_in = head_next;
         end else begin
            occ_in = occ_ff + CW'(1);
         end
      end
      if (dp_cmd.advance_clock) begin
         aging_in = aging_ff + TIME_W'(dt_ff);
      end
      if (dp_cmd.pop_head) begin
         head_in = head_next;
         occ_in  = occ_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         occ_ff       <= '0;
         aging_ff     <= '0;
         seen_ff      <= '0;
         lifetime_ff  <= LIFETIME_RESET;
         floor_ff     <= FLOOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         aging_ff <= aging_in;
         seen_ff  <= seen_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_LIFETIME: lifetime_ff <= csr_wdata;
               CSR_FLOOR:    floor_ff    <= csr_wdata;
               default:      ;
            endcase
         end
         if (dp_cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         px_ff      <= req_tdata[0 +: POS_W];
         py_ff      <= req_tdata[32 +: POS_W];
         kind_ff    <= req_tdata[64 +: KIND_W];
         now_ff     <= req_tdata[72 +: TIME_W];
         dt_ff      <= req_tdata[104 +: DT_W];
         evicted_ff <= 1'b0;
         expired_ff <= '0;
      end else begin
         if (dp_cmd.commit_raise) begin
            evicted_ff <= queue_full;
         end
         if (dp_cmd.pop_head) begin
            expired_ff <= expired_ff + CW'(1);
         end
      end
      if (dp_cmd.set_status) begin
         status_ff <= dp_cmd.status_code;
      end
      if (dp_cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= {2'b00, latest_kind, latest_y, latest_x, latest_valid,
                           CNT_OUT_W'(occ_ff), CNT_OUT_W'(expired_ff), evicted_ff};
      end
   end

   assign latest_valid = (occ_ff != '0);
   assign latest_x     = latest_valid ? entry_rd[0 +: POS_W] : '0;
   assign latest_y     = latest_valid ? entry_rd[POS_W +: POS_W] : '0;
   assign latest_kind  = latest_valid ? entry_rd[2*POS_W +: KIND_W] : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, occ_ff} <= DEPTH_W)
      else $error("occupancy beyond queue depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.pop_head |-> occ_ff != '0)
      else $error("pop from an empty queue");

   a_commit_good_kind: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit_raise |-> !dp_status.bad_kind && !dp_status.rate_hit)
      else $error("raise committed against a drop condition");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_rsp |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten while stalled");

endmodule
